// ===== design/pwm_pkg.sv =====
// package for the pwm period calculator: widths, register indexes, divider step
// no dependencies
package pwm_pkg;
    localparam int CoreW = 28;
    localparam int FreqW = 24;
    localparam int ReqW = 32;
    localparam int TickW = 17;
    localparam int IdxW = 2;
    localparam logic [TickW-1:0] MaxTicks = 17'd65536;
    localparam logic [TickW-1:0] MinTicks = 17'd2;

    typedef enum logic [IdxW-1:0] {
        REG_CORE_CLOCK = 2'd0,
        REG_MIN_FREQ = 2'd1,
        REG_MAX_FREQ = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CoreW-1:0] rem;
        logic [CoreW-1:0] quo;
    } div_state_t;

    // one restoring division step: shift in next dividend bit, subtract if fits
    function automatic div_state_t div_step(div_state_t s, logic [CoreW-1:0] d);
        logic [CoreW:0] r;
        div_state_t o;
        r = {s.rem, s.quo[CoreW-1]};
        o.quo = {s.quo[CoreW-2:0], 1'b0};
        if (r >= {1'b0, d})
        begin
            r = r - {1'b0, d};
            o.quo[0] = 1'b1;
        end
        o.rem = r[CoreW-1:0];
        return o;
    endfunction
endpackage

// ===== design/pwm_if.sv =====
// valid/ready channel interfaces for the pwm period calculator
// depends on pwm_pkg
interface pwm_req_if;
    import pwm_pkg::*;
    logic valid;
    logic ready;
    logic [ReqW-1:0] requested_hz;
    modport source (output valid, output requested_hz, input ready);
    modport sink (input valid, input requested_hz, output ready);
endinterface

interface pwm_res_if;
    import pwm_pkg::*;
    logic valid;
    logic ready;
    logic [15:0] period_reload;
    logic [15:0] compare_value;
    logic [CoreW-1:0] achieved_hz;
    modport source (output valid, output period_reload, output compare_value,
                    output achieved_hz, input ready);
    modport sink (input valid, input period_reload, input compare_value,
                  input achieved_hz, output ready);
endinterface

interface pwm_cfg_if;
    import pwm_pkg::*;
    logic valid;
    logic ready;
    logic [IdxW-1:0] index;
    logic [CoreW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/pwm_divider.sv =====
// pipelined restoring divider, 4 quotient bits per stage, 7 stages
// depends on pwm_pkg; carries a side tag alongside each quotient
module pwm_divider
    import pwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [CoreW-1:0] dividend,
    input  logic [CoreW-1:0] divisor,
    input  logic [CoreW-1:0] tag_in,
    output logic             out_valid,
    output logic [CoreW-1:0] quotient,
    output logic [CoreW-1:0] tag_out
);
    localparam int Stages = 7;
    localparam int BitsPer = CoreW / Stages;

    logic [Stages-1:0] vld_reg;
    div_state_t st_reg [Stages];
    logic [CoreW-1:0] dv_reg [Stages];
    logic [CoreW-1:0] tg_reg [Stages];
    div_state_t st_next [Stages];

    // per-stage combinational steps
    always_comb
    begin
        div_state_t s;
        // first stage starts from the incoming dividend
        s.rem = '0;
        s.quo = dividend;
        for (int b = 0; b < BitsPer; b++)
        begin
            s = div_step(s, divisor);
        end
        st_next[0] = s;
        for (int k = 1; k < Stages; k++)
        begin
            s = st_reg[k-1];
            for (int b = 0; b < BitsPer; b++)
            begin
                s = div_step(s, dv_reg[k-1]);
            end
            st_next[k] = s;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    // payload chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= st_next[0];
            dv_reg[0] <= divisor;
            tg_reg[0] <= tag_in;
            for (int k = 1; k < Stages; k++)
            begin
                st_reg[k] <= st_next[k];
                dv_reg[k] <= dv_reg[k-1];
                tg_reg[k] <= tg_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Stages-1];
    assign quotient  = st_reg[Stages-1].quo;
    assign tag_out   = tg_reg[Stages-1];
endmodule

// ===== design/pwm_period_from_frequency_core.sv =====
// pwm period calculator: clamp stage, two pipelined dividers, tick fixup, output stage
// depends on pwm_pkg, pwm_if and pwm_divider
//
// usage:
//   cfg: write register 0 core clock, 1 min freq, 2 max freq; always ready;
//        write only while idle
//   req: one requested frequency per request; res: one result per request
//   path from request to result valid: clamp, 7-stage tick
//   divider, fixup, 7-stage achieved-frequency divider, output register
//   throughput: one request per cycle while the output is not stalled, set
//   by the two pipelined dividers which retire 4 quotient bits per stage
//   reset: registers return to 72 MHz, 20 kHz, 200 kHz; pipeline empties
//   stall: when res.ready is low and the output holds a result, the whole
//   pipeline freezes and req.ready drops; nothing is lost or repeated.
//   bubbles inside the pipeline are not squeezed out during a stall
//   zero divisor saturates to the maximum tick count
module pwm_period_from_frequency_core
    import pwm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    pwm_cfg_if.sink cfg,
    pwm_req_if.sink req,
    pwm_res_if.source res
);
    logic [CoreW-1:0] core_reg;
    logic [FreqW-1:0] min_reg, max_reg;
    logic adv;

    // config registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_reg <= 28'd72000000;
            min_reg  <= 24'd20000;
            max_reg  <= 24'd200000;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_CORE_CLOCK: core_reg <= cfg.data;
                REG_MIN_FREQ:   min_reg  <= cfg.data[FreqW-1:0];
                REG_MAX_FREQ:   max_reg  <= cfg.data[FreqW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless output is full and stalled
    assign adv = !res.valid || res.ready;
    assign req.ready = adv;

    // clamp stage
    logic [ReqW-1:0] f1;
    logic [FreqW-1:0] f_next, f_reg;
    logic v_f_reg;
    always_comb
    begin
        f1 = req.requested_hz;
        if (f1 < {8'd0, min_reg})
        begin
            f1 = {8'd0, min_reg};
        end
        if (f1 > {8'd0, max_reg})
        begin
            f1 = {8'd0, max_reg};
        end
        f_next = f1[FreqW-1:0];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_f_reg <= req.valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg <= f_next;
        end
    end

    // tick divider; tag marks zero frequency
    logic v_d1;
    logic [CoreW-1:0] q1, tag1;
    pwm_divider u_div_ticks (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v_f_reg),
        .dividend(core_reg), .divisor({4'd0, f_reg}),
        .tag_in({27'd0, f_reg == '0}),
        .out_valid(v_d1), .quotient(q1), .tag_out(tag1)
    );

    // tick fixup: round to even, clamp
    logic [CoreW:0] t_even;
    logic [TickW-1:0] t_next, t_reg;
    logic v_t_reg;
    always_comb
    begin
        t_even = {1'b0, q1} + {{CoreW{1'b0}}, q1[0]};
        if (tag1[0])
        begin
            t_next = MaxTicks;
        end
        else if (t_even < {{(CoreW+1-TickW){1'b0}}, MinTicks})
        begin
            t_next = MinTicks;
        end
        else if (t_even > {{(CoreW+1-TickW){1'b0}}, MaxTicks})
        begin
            t_next = MaxTicks;
        end
        else
        begin
            t_next = t_even[TickW-1:0];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_t_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_t_reg <= v_d1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg <= t_next;
        end
    end

    // achieved frequency divider, ticks ride along as tag
    logic v_d2;
    logic [CoreW-1:0] q2, tag2;
    pwm_divider u_div_freq (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v_t_reg),
        .dividend(core_reg), .divisor({11'd0, t_reg}),
        .tag_in({11'd0, t_reg}),
        .out_valid(v_d2), .quotient(q2), .tag_out(tag2)
    );

    // output register
    logic v_o_reg;
    logic [15:0] pr_reg, cv_reg;
    logic [CoreW-1:0] ah_reg;
    logic [TickW-1:0] tk;
    logic [TickW-1:0] tk_m1;
    assign tk = tag2[TickW-1:0];
    assign tk_m1 = tk - 17'd1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_o_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_o_reg <= v_d2;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg <= tk_m1[15:0];
            cv_reg <= tk[16:1];
            ah_reg <= q2;
        end
    end
    assign res.valid = v_o_reg;
    assign res.period_reload = pr_reg;
    assign res.compare_value = cv_reg;
    assign res.achieved_hz = ah_reg;
endmodule

// ===== design/pwm_checker.sv =====
// port-level checker for the pwm period calculator, bound to the top level
// depends on pwm_pkg and pwm_if
module pwm_checker
    import pwm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input logic [15:0] period_reload,
    input logic [15:0] compare_value
);
    // a stalled result stays valid and its period reload holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(period_reload))
        else $error("stalled result changed");

    // input stalls only when output is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> res_valid && !res_ready)
        else $error("input blocked without output stall");

    // reload is tick count minus one, compare is half tick count
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({1'b0, compare_value} == ({1'b0, period_reload} + 17'd1) >> 1)
                      && period_reload != 16'd0)
        else $error("reload and compare disagree");
endmodule

bind pwm_period_from_frequency_core pwm_checker u_pwm_checker (
    .clk(clk), .rst_n(rst_n), .req_ready(req.ready), .res_valid(res.valid),
    .res_ready(res.ready), .period_reload(res.period_reload),
    .compare_value(res.compare_value)
);
